/* rtl/kmu_pkg.sv */
// Shared constants and codes for the track measurement update block.
package kmu_pkg;

	localparam int LIMIT_BITS = 33;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 33'd4290672328;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_FILTER = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_VAR  = 2'd1;
	localparam logic [1:0] STAT_SPHI = 2'd2;

	localparam logic [4:0] NUM_PARAMS = 5'd5;
	localparam logic [4:0] IDX_COV0   = 5'd5;
	localparam logic [4:0] IDX_CHI    = 5'd20;
	localparam logic [4:0] IDX_DOF    = 5'd21;

	localparam logic [9:0] DOF_MAX  = 10'd1023;
	localparam logic [9:0] DOF_STEP = 10'd2;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

endpackage

/* rtl/kmu_if.sv */
// Valid/ready channel interfaces for the request and response beats.
interface kmu_req_if #(parameter int VALUE_BITS = 48);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic [4:0]                   element_index;
	logic signed [VALUE_BITS-1:0] element_value;
	logic signed [VALUE_BITS-1:0] hit_y;
	logic signed [VALUE_BITS-1:0] hit_z;
	logic [VALUE_BITS-2:0]        hit_var_y;
	logic [VALUE_BITS-2:0]        hit_var_z;

	modport source (output valid, action, element_index, element_value, hit_y, hit_z,
		hit_var_y, hit_var_z, input ready);
	modport sink (input valid, action, element_index, element_value, hit_y, hit_z,
		hit_var_y, hit_var_z, output ready);
endinterface

interface kmu_rsp_if #(parameter int VALUE_BITS = 48);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic signed [VALUE_BITS-1:0] read_value;
	logic [VALUE_BITS-2:0]        chi_square_total;
	logic [9:0]                   dof_total;

	modport source (output valid, status, read_value, chi_square_total, dof_total,
		input ready);
	modport sink (input valid, status, read_value, chi_square_total, dof_total,
		output ready);
endinterface

/* rtl/kmu_alu.sv */
// Shared bit-serial multiply and divide unit with rounding and saturation.
module kmu_alu #(
	parameter int VALUE_BITS    = 48,
	parameter int FRACTION_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           op,
	input  logic                           neg,
	input  logic [VALUE_BITS-1:0]          opa,
	input  logic [VALUE_BITS-1:0]          opb,
	input  logic [2*VALUE_BITS-1:0]        num,
	input  logic [VALUE_BITS-1:0]          den,
	output logic                           done,
	output logic signed [VALUE_BITS-1:0]   res,
	output logic [2*VALUE_BITS-1:0]        prod
);
	import kmu_pkg::*;

	localparam int W    = VALUE_BITS;
	localparam int CNTW = $clog2(2 * W + 1);

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_BUSY = 2'd1;
	localparam logic [1:0] A_FIN  = 2'd2;

	logic [1:0]        st_q;
	logic              op_q;
	logic              neg_q;
	logic [2*W-1:0]    acc_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      ma_q;
	logic [W-1:0]      mb_q;
	logic [W-1:0]      den_q;
	logic [CNTW-1:0]   cnt_q;
	logic signed [W-1:0] res_q;
	logic              done_q;

	logic [W:0]        trial;
	logic              fits;
	logic [2*W:0]      mag;
	logic [2*W:0]      lim;
	logic [2*W:0]      sat;
	logic              rnd;

	always_comb begin
		trial = {rem_q, acc_q[2*W-1]};
		fits  = trial >= {1'b0, den_q};
		rnd   = rem_q >= (den_q - rem_q);
		if (op_q == OP_MUL) begin
			mag = ({1'b0, acc_q} + ((2*W+1)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		end else begin
			mag = {1'b0, acc_q} + (2*W+1)'(rnd);
		end
		lim = neg_q ? ((2*W+1)'(1) << (W - 1)) : (((2*W+1)'(1) << (W - 1)) - (2*W+1)'(1));
		sat = (mag > lim) ? lim : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				A_IDLE: begin
					if (start) begin
						st_q  <= A_BUSY;
						cnt_q <= (op == OP_DIV) ? CNTW'(2 * W) : CNTW'(W);
					end
				end
				A_BUSY: begin
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) st_q <= A_FIN;
				end
				A_FIN: begin
					st_q   <= A_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			A_IDLE: begin
				if (start) begin
					op_q  <= op;
					neg_q <= neg;
					ma_q  <= opa;
					mb_q  <= opb;
					den_q <= den;
					rem_q <= '0;
					acc_q <= (op == OP_DIV) ? num : '0;
				end
			end
			A_BUSY: begin
				if (op_q == OP_MUL) begin
					acc_q <= {acc_q[2*W-2:0], 1'b0} + (mb_q[W-1] ? {{W{1'b0}}, ma_q} : '0);
					mb_q  <= {mb_q[W-2:0], 1'b0};
				end else begin
					// Restoring division: the quotient shifts into the numerator register.
					rem_q <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
					acc_q <= {acc_q[2*W-2:0], fits};
				end
			end
			A_FIN: begin
				res_q <= neg_q ? -$signed(sat[W-1:0]) : $signed(sat[W-1:0]);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;
	assign prod = acc_q;

endmodule

/* rtl/kalman_track_measurement_update.sv */
// Top level: track state, sequencer and handshakes of the measurement update.
// Usage:
// Request beats on req carry an action: load or read one of 22 track elements
// (five parameters, fifteen covariance words, chi-square sum, dof count) or
// filter one y,z hit with its variances. Each request gives one response beat
// on rsp with the status, the read value and the running chi-square and dof.
// The sin phi limit register is written through cfg_wr_en / cfg_wr_data; the
// user must only write it while idle (unchecked); zero disables the limit test.
// Sequence: a load or read answers in the cycle after acceptance. A filter runs
// 23 steps on one shared bit-serial multiply/divide unit: seven divisions and
// sixteen multiplies, between the setup and check states and the response.
// A rejected filter answers after the variance check, or after the sin phi
// limit test that follows the sin phi step.
// One item is in flight at a time; req.ready is high only while idle.
// Reset clears all track elements to zero and loads the limit with 0.999.
// When rsp is stalled, the response beat holds and no request is taken.
module kalman_track_measurement_update #(
	parameter int VALUE_BITS    = 48,
	parameter int FRACTION_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [kmu_pkg::LIMIT_BITS-1:0]  cfg_wr_data,
	kmu_req_if.sink                         req,
	kmu_rsp_if.source                       rsp
);
	import kmu_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int CW = (W > LIMIT_BITS) ? W : LIMIT_BITS;
	localparam logic signed [W-1:0] VMAX = W'((65'd1 << (W - 1)) - 65'd1);
	localparam logic signed [W-1:0] VMIN = -VMAX - W'(1);
	localparam logic signed [W-1:0] MIN_VAR =
		W'(((65'd1 << FRACTION_BITS) + 65'd99999999) / 65'd100000000);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_ISSUE = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_LIMIT = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	localparam logic [4:0] STEP_SPHI = 5'd5;
	localparam logic [4:0] STEP_LAST = 5'd22;

	function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] s);
		if (s > $signed({VMAX[W-1], VMAX})) return VMAX;
		if (s < $signed({VMIN[W-1], VMIN})) return VMIN;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		return sat_w($signed({a[W-1], a}) + $signed({b[W-1], b}));
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		return sat_w($signed({a[W-1], a}) - $signed({b[W-1], b}));
	endfunction

	function automatic logic [W-1:0] magw(input logic signed [W-1:0] x);
		return x[W-1] ? W'(-x) : W'(x);
	endfunction

	logic [2:0]              st_q;
	logic [4:0]              step_q;
	logic [LIMIT_BITS-1:0]   limit_q;
	logic signed [W-1:0]     p_q [5];
	logic signed [W-1:0]     c_q [15];
	logic [W-2:0]            chi_q;
	logic [9:0]              dof_q;
	logic [1:0]              status_q;
	logic signed [W-1:0]     rd_q;

	logic signed [W-1:0]     hy_q, hz_q;
	logic [W-2:0]            vy_q, vz_q;
	logic signed [W-1:0]     e0_q, e1_q, r0_q, r1_q, sp_q, chi0_q;
	logic signed [W-1:0]     s_q [5];
	logic signed [W-1:0]     k_q [5];

	logic                    alu_start;
	logic                    alu_op;
	logic                    alu_neg;
	logic [W-1:0]            alu_a, alu_b, alu_den;
	logic [2*W-1:0]          alu_num;
	logic                    alu_done;
	logic signed [W-1:0]     alu_res;
	logic [2*W-1:0]          alu_prod;

	logic signed [W-1:0]     op_x, op_y;
	logic                    use_e1;
	logic                    chi_div;

	logic                    acc_req;
	logic signed [W-1:0]     ld_val;
	logic [3:0]              cov_idx;
	logic signed [W-1:0]     rd_val;
	logic signed [W-1:0]     chi_new;
	logic signed [W-1:0]     chi_acc;
	logic [10:0]             dof_sum;

	assign acc_req = req.valid && req.ready;
	assign ld_val  = req.element_value;
	assign cov_idx = 4'(req.element_index - IDX_COV0);

	always_comb begin
		rd_val = '0;
		if (req.element_index < NUM_PARAMS) rd_val = p_q[req.element_index[2:0]];
		else if (req.element_index < IDX_CHI) rd_val = c_q[cov_idx];
		else if (req.element_index == IDX_CHI) rd_val = $signed({1'b0, chi_q});
		else if (req.element_index == IDX_DOF) rd_val = $signed(W'(dof_q));
	end

	// Operand selection for each step of the update sequence.
	always_comb begin
		alu_op  = OP_MUL;
		op_x    = k_q[0];
		op_y    = r0_q;
		use_e1  = 1'b0;
		chi_div = 1'b0;
		case (step_q)
			5'd0:  begin alu_op = OP_DIV; op_x = s_q[0]; end
			5'd1:  begin alu_op = OP_DIV; op_x = s_q[2]; end
			5'd2:  begin alu_op = OP_DIV; op_x = s_q[4]; end
			5'd3:  begin alu_op = OP_DIV; op_x = s_q[1]; use_e1 = 1'b1; end
			5'd4:  begin alu_op = OP_DIV; op_x = s_q[3]; use_e1 = 1'b1; end
			5'd5:  begin op_x = k_q[2]; op_y = r0_q; end
			5'd6:  begin op_x = r0_q; op_y = r0_q; end
			5'd7:  begin alu_op = OP_DIV; chi_div = 1'b1; end
			5'd8:  begin op_x = r1_q; op_y = r1_q; end
			5'd9:  begin alu_op = OP_DIV; chi_div = 1'b1; use_e1 = 1'b1; end
			5'd10: begin op_x = k_q[0]; op_y = r0_q; end
			5'd11: begin op_x = k_q[1]; op_y = r1_q; end
			5'd12: begin op_x = k_q[3]; op_y = r1_q; end
			5'd13: begin op_x = k_q[4]; op_y = r0_q; end
			5'd14: begin op_x = k_q[0]; op_y = s_q[0]; end
			5'd15: begin op_x = k_q[2]; op_y = s_q[0]; end
			5'd16: begin op_x = k_q[2]; op_y = s_q[2]; end
			5'd17: begin op_x = k_q[4]; op_y = s_q[0]; end
			5'd18: begin op_x = k_q[4]; op_y = s_q[2]; end
			5'd19: begin op_x = k_q[4]; op_y = s_q[4]; end
			5'd20: begin op_x = k_q[1]; op_y = s_q[1]; end
			5'd21: begin op_x = k_q[3]; op_y = s_q[1]; end
			5'd22: begin op_x = k_q[3]; op_y = s_q[3]; end
			default: ;
		endcase
		alu_a   = magw(op_x);
		alu_b   = magw(op_y);
		alu_den = use_e1 ? W'(e1_q) : W'(e0_q);
		alu_num = chi_div ? alu_prod : ({{W{1'b0}}, magw(op_x)} << FRACTION_BITS);
		if (chi_div) alu_neg = 1'b0;
		else if (alu_op == OP_DIV) alu_neg = op_x[W-1];
		else alu_neg = op_x[W-1] ^ op_y[W-1];
		alu_start = (st_q == S_ISSUE);
	end

	kmu_alu #(
		.VALUE_BITS    (VALUE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.op     (alu_op),
		.neg    (alu_neg),
		.opa    (alu_a),
		.opb    (alu_b),
		.num    (alu_num),
		.den    (alu_den),
		.done   (alu_done),
		.res    (alu_res),
		.prod   (alu_prod)
	);

	assign chi_new = sat_add(chi0_q, alu_res);
	assign chi_acc = sat_add($signed({1'b0, chi_q}), chi_new);
	assign dof_sum = {1'b0, dof_q} + {1'b0, DOF_STEP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			step_q   <= '0;
			limit_q  <= LIMIT_RESET;
			chi_q    <= '0;
			dof_q    <= '0;
			status_q <= STAT_OK;
			rd_q     <= '0;
			for (int i = 0; i < 5; i++) p_q[i] <= '0;
			for (int i = 0; i < 15; i++) c_q[i] <= '0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			case (st_q)
				S_IDLE: begin
					if (acc_req) begin
						status_q <= STAT_OK;
						rd_q     <= '0;
						if (req.action == ACT_FILTER) begin
							st_q <= S_PREP;
						end else begin
							st_q <= S_RESP;
							if (req.action == ACT_READ) rd_q <= rd_val;
							if (req.action == ACT_LOAD) begin
								if (req.element_index < NUM_PARAMS) begin
									p_q[req.element_index[2:0]] <= ld_val;
								end else if (req.element_index < IDX_CHI) begin
									c_q[cov_idx] <= ld_val;
								end else if (req.element_index == IDX_CHI) begin
									chi_q <= ld_val[W-1] ? '0 : ld_val[W-2:0];
								end else if (req.element_index == IDX_DOF) begin
									if (ld_val[W-1]) dof_q <= '0;
									else if (ld_val > $signed(W'(DOF_MAX))) dof_q <= DOF_MAX;
									else dof_q <= ld_val[9:0];
								end
							end
						end
					end
				end
				S_PREP: st_q <= S_CHECK;
				S_CHECK: begin
					step_q <= '0;
					if (e0_q < MIN_VAR || e1_q < MIN_VAR) begin
						status_q <= STAT_VAR;
						st_q     <= S_RESP;
					end else begin
						st_q <= S_ISSUE;
					end
				end
				S_ISSUE: st_q <= S_WAIT;
				S_WAIT: begin
					if (alu_done) begin
						case (step_q)
							5'd9: begin
								chi_q <= chi_acc[W-2:0];
								dof_q <= (dof_sum > {1'b0, DOF_MAX}) ? DOF_MAX : dof_sum[9:0];
							end
							5'd10: begin
								p_q[0] <= sat_add(p_q[0], alu_res);
								p_q[2] <= sp_q;
							end
							5'd11: p_q[1] <= sat_add(p_q[1], alu_res);
							5'd12: p_q[3] <= sat_add(p_q[3], alu_res);
							5'd13: p_q[4] <= sat_add(p_q[4], alu_res);
							5'd14: c_q[0] <= sat_sub(c_q[0], alu_res);
							5'd15: c_q[3] <= sat_sub(c_q[3], alu_res);
							5'd16: c_q[5] <= sat_sub(c_q[5], alu_res);
							5'd17: c_q[10] <= sat_sub(c_q[10], alu_res);
							5'd18: c_q[12] <= sat_sub(c_q[12], alu_res);
							5'd19: c_q[14] <= sat_sub(c_q[14], alu_res);
							5'd20: c_q[2] <= sat_sub(c_q[2], alu_res);
							5'd21: c_q[7] <= sat_sub(c_q[7], alu_res);
							5'd22: c_q[9] <= sat_sub(c_q[9], alu_res);
							default: ;
						endcase
						if (step_q == STEP_SPHI) begin
							st_q <= S_LIMIT;
						end else if (step_q == STEP_LAST) begin
							st_q <= S_RESP;
						end else begin
							step_q <= step_q + 5'd1;
							st_q   <= S_ISSUE;
						end
					end
				end
				S_LIMIT: begin
					if (limit_q != '0 && CW'(magw(sp_q)) >= CW'(limit_q)) begin
						status_q <= STAT_SPHI;
						st_q     <= S_RESP;
					end else begin
						step_q <= step_q + 5'd1;
						st_q   <= S_ISSUE;
					end
				end
				S_RESP: begin
					if (rsp.ready) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of a filter item; no reset needed.
	always_ff @(posedge clk) begin
		if (acc_req) begin
			hy_q <= req.hit_y;
			hz_q <= req.hit_z;
			vy_q <= req.hit_var_y;
			vz_q <= req.hit_var_z;
		end
		if (st_q == S_PREP) begin
			e0_q   <= sat_add($signed({1'b0, vy_q}), c_q[0]);
			e1_q   <= sat_add($signed({1'b0, vz_q}), c_q[2]);
			r0_q   <= sat_sub(hy_q, p_q[0]);
			r1_q   <= sat_sub(hz_q, p_q[1]);
			s_q[0] <= c_q[0];
			s_q[1] <= c_q[2];
			s_q[2] <= c_q[3];
			s_q[3] <= c_q[7];
			s_q[4] <= c_q[10];
		end
		if (st_q == S_WAIT && alu_done) begin
			case (step_q)
				5'd0: k_q[0] <= alu_res;
				5'd1: k_q[2] <= alu_res;
				5'd2: k_q[4] <= alu_res;
				5'd3: k_q[1] <= alu_res;
				5'd4: k_q[3] <= alu_res;
				5'd5: sp_q   <= sat_add(p_q[2], alu_res);
				5'd7: chi0_q <= alu_res;
				default: ;
			endcase
		end
	end

	assign req.ready            = (st_q == S_IDLE);
	assign rsp.valid            = (st_q == S_RESP);
	assign rsp.status           = status_q;
	assign rsp.read_value       = rd_q;
	assign rsp.chi_square_total = chi_q;
	assign rsp.dof_total        = dof_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> st_q == S_WAIT)
		else $error("arithmetic unit finished outside of a wait step");

	a_filter_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_req && req.action == ACT_FILTER) |=> st_q == S_PREP)
		else $error("accepted filter beat did not start the sequence");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request taken while a response beat is pending");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ISSUE || st_q == S_WAIT) |-> step_q <= STEP_LAST)
		else $error("sequence step beyond the last step");

endmodule
